/* hdl/wht_pkg.sv */
// Package with the item types, register codes and constants of the thermostat.
`timescale 1ns / 1ps

package wht_pkg;

    // Operating modes as shown on the mode field of a result item.
    localparam logic [1:0] MODE_OFF = 2'd0;
    localparam logic [1:0] MODE_RUN = 2'd1;
    localparam logic [1:0] MODE_SET = 2'd2;

    // Configuration register indexes.
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 10;
    localparam logic [CFG_INDEX_W-1:0] CFG_MIN_SETPOINT    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_SETPOINT    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_SETPOINT_STEP   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_HYSTERESIS_BAND = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_EXIT_TIMEOUT    = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_BLINK_PERIOD    = 3'd5;

    // Configuration reset values.
    localparam logic [6:0] RST_MIN_SETPOINT    = 7'd35;
    localparam logic [6:0] RST_MAX_SETPOINT    = 7'd75;
    localparam logic [3:0] RST_SETPOINT_STEP   = 4'd5;
    localparam logic [3:0] RST_HYSTERESIS_BAND = 4'd5;
    localparam logic [9:0] RST_EXIT_TIMEOUT    = 10'd500;
    localparam logic [4:0] RST_BLINK_PERIOD    = 5'd20;

    // Controller state reset values.
    localparam logic [6:0] RST_SETPOINT     = 7'd60;
    localparam logic [8:0] RST_CURRENT_TEMP = 9'd15;

    // Sensor conversion: degrees = adc * ADC_SCALE / ADC_FULL.
    localparam int ADC_W     = 10;
    localparam int DEG_W     = 9;
    localparam int ADC_SCALE = 500;
    localparam int ADC_FULL  = 1023;
    localparam int DEG_MAX   = 500;

    // Averaging window and the reciprocal used to divide the ring sum by it.
    localparam int WINDOW_LEN = 10;
    localparam int IDX_W      = $clog2(WINDOW_LEN);
    localparam int SUM_W      = $clog2(WINDOW_LEN * DEG_MAX + 1);
    localparam int AVG_SHIFT  = 20;
    localparam int RECIP_W    = 20;
    localparam int AVG_RECIP  = ((1 << AVG_SHIFT) + WINDOW_LEN - 1) / WINDOW_LEN;

    // Configuration register set.
    typedef struct packed {
        logic [6:0] min_setpoint;
        logic [6:0] max_setpoint;
        logic [3:0] setpoint_step;
        logic [3:0] hysteresis_band;
        logic [9:0] exit_timeout;
        logic [4:0] blink_period;
    } cfg_t;

    // Input item.
    typedef struct packed {
        logic             onoff_press;
        logic             up_press;
        logic             down_press;
        logic             sample_valid;
        logic [ADC_W-1:0] adc_sample;
    } in_item_t;

    // Result item.
    typedef struct packed {
        logic [1:0]       mode;
        logic             heater_on;
        logic             cooler_on;
        logic             display_on;
        logic [DEG_W-1:0] display_value;
    } out_item_t;

    // Item after conversion of the sample to degrees.
    typedef struct packed {
        logic             onoff_press;
        logic             up_press;
        logic             down_press;
        logic             sample_valid;
        logic [DEG_W-1:0] degrees;
    } conv_item_t;

    // Item carrying the new window average.
    typedef struct packed {
        logic             onoff_press;
        logic             up_press;
        logic             down_press;
        logic             sample_valid;
        logic [DEG_W-1:0] average;
    } avg_item_t;

endpackage

/* hdl/water_heater_thermostat.sv */
// Top level of the thermostat: configuration registers and the item pipeline.
`timescale 1ns / 1ps

// Hysteresis thermostat for a water heater. Each accepted item is one tick carrying
// button presses and an optional sensor sample, and gives exactly one result item.
// The block takes one item per clock until the stages fill behind a stalled output, and
// holds up to four items in flight: sample conversion, averaging ring update, division
// of the ring sum, and the mode logic that loads the result register, one register stage
// each; a result is offered once its item has passed through all four. Any stage
// moves on whenever the stage after it is free or emptying, so a waiting result stops
// intake only once all four stages hold an item.
// The averaging ring is cleared directly by reset, with no sweep. Configuration is
// written through cfg_write, cfg_index and cfg_data and takes effect at once; write
// it only while no item is in flight.
module water_heater_thermostat (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [wht_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [wht_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                item_valid,
    output logic                                item_ready,
    input  wht_pkg::in_item_t                   item,
    output logic                                result_valid,
    input  logic                                result_ready,
    output wht_pkg::out_item_t                  result
);

    wht_pkg::cfg_t      cfg_reg;
    wht_pkg::cfg_t      cfg_next;
    logic               conv_valid;
    logic               conv_ready;
    wht_pkg::conv_item_t conv;
    logic               avg_valid;
    logic               avg_ready;
    wht_pkg::avg_item_t avg;

    // Register writes; indexes beyond the list are ignored.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                wht_pkg::CFG_MIN_SETPOINT:    cfg_next.min_setpoint    = cfg_data[6:0];
                wht_pkg::CFG_MAX_SETPOINT:    cfg_next.max_setpoint    = cfg_data[6:0];
                wht_pkg::CFG_SETPOINT_STEP:   cfg_next.setpoint_step   = cfg_data[3:0];
                wht_pkg::CFG_HYSTERESIS_BAND: cfg_next.hysteresis_band = cfg_data[3:0];
                wht_pkg::CFG_EXIT_TIMEOUT:    cfg_next.exit_timeout    = cfg_data[9:0];
                wht_pkg::CFG_BLINK_PERIOD:    cfg_next.blink_period    = cfg_data[4:0];
                default:                      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_setpoint    <= wht_pkg::RST_MIN_SETPOINT;
            cfg_reg.max_setpoint    <= wht_pkg::RST_MAX_SETPOINT;
            cfg_reg.setpoint_step   <= wht_pkg::RST_SETPOINT_STEP;
            cfg_reg.hysteresis_band <= wht_pkg::RST_HYSTERESIS_BAND;
            cfg_reg.exit_timeout    <= wht_pkg::RST_EXIT_TIMEOUT;
            cfg_reg.blink_period    <= wht_pkg::RST_BLINK_PERIOD;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Sample conversion stage.
    wht_convert u_convert (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .conv_valid (conv_valid),
        .conv_ready (conv_ready),
        .conv       (conv)
    );

    // Averaging ring and division stages.
    wht_average u_average (
        .clk        (clk),
        .rst_n      (rst_n),
        .conv_valid (conv_valid),
        .conv_ready (conv_ready),
        .conv       (conv),
        .avg_valid  (avg_valid),
        .avg_ready  (avg_ready),
        .avg        (avg)
    );

    // Mode controller and result register.
    wht_control u_control (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .avg_valid    (avg_valid),
        .avg_ready    (avg_ready),
        .avg          (avg),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

/* hdl/wht_convert.sv */
// Input stage: converts the raw sensor sample to whole degrees and registers the item.
`timescale 1ns / 1ps

module wht_convert (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_ready,
    input  wht_pkg::in_item_t   item,
    output logic                conv_valid,
    input  logic                conv_ready,
    output wht_pkg::conv_item_t conv
);

    logic                     conv_valid_reg;
    logic                     conv_valid_next;
    wht_pkg::conv_item_t      conv_reg;
    wht_pkg::conv_item_t      conv_next;
    logic [18:0]              scaled;
    logic [wht_pkg::DEG_W-1:0] quot_low;
    logic [10:0]              rem_est;
    logic                     accept;

    // The stage takes an item when empty or when its item leaves this cycle.
    assign item_ready = !conv_valid_reg || conv_ready;
    assign accept     = item_valid && item_ready;

    // Division by 1023 = 2^10 - 1: the quotient of x >> 10 is low by at most one,
    // and the remainder estimate q + (x mod 1024) stays below twice the divisor.
    assign scaled   = 19'(item.adc_sample) * 19'(wht_pkg::ADC_SCALE);
    assign quot_low = scaled[18:10];
    assign rem_est  = 11'(quot_low) + 11'(scaled[9:0]);

    always_comb
    begin
        conv_next.onoff_press  = item.onoff_press;
        conv_next.up_press     = item.up_press;
        conv_next.down_press   = item.down_press;
        conv_next.sample_valid = item.sample_valid;
        conv_next.degrees      = quot_low + wht_pkg::DEG_W'(rem_est >= 11'(wht_pkg::ADC_FULL));
    end

    // Valid flag of the stage.
    always_comb
    begin
        if (accept)
        begin
            conv_valid_next = 1'b1;
        end
        else if (conv_ready)
        begin
            conv_valid_next = 1'b0;
        end
        else
        begin
            conv_valid_next = conv_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            conv_valid_reg <= 1'b0;
        end
        else
        begin
            conv_valid_reg <= conv_valid_next;
        end
    end

    // Payload register.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            conv_reg <= conv_next;
        end
    end

    assign conv_valid = conv_valid_reg;
    assign conv       = conv_reg;

endmodule

/* hdl/wht_average.sv */
// Averaging stages: sample ring with running sum, then division of the sum by the window length.
`timescale 1ns / 1ps

module wht_average (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                conv_valid,
    output logic                conv_ready,
    input  wht_pkg::conv_item_t conv,
    output logic                avg_valid,
    input  logic                avg_ready,
    output wht_pkg::avg_item_t  avg
);

    typedef struct packed {
        logic                      onoff_press;
        logic                      up_press;
        logic                      down_press;
        logic                      sample_valid;
        logic [wht_pkg::SUM_W-1:0] sum;
    } sum_item_t;

    logic [wht_pkg::DEG_W-1:0] ring_reg [wht_pkg::WINDOW_LEN];
    logic [wht_pkg::SUM_W-1:0] ring_sum_reg;
    logic [wht_pkg::SUM_W-1:0] ring_sum_next;
    logic [wht_pkg::IDX_W-1:0] index_reg;
    logic [wht_pkg::IDX_W-1:0] index_next;

    logic                      sum_valid_reg;
    logic                      sum_valid_next;
    sum_item_t                 sum_item_reg;
    sum_item_t                 sum_item_next;
    logic                      sum_ready;
    logic                      sum_load;

    logic                      avg_valid_reg;
    logic                      avg_valid_next;
    wht_pkg::avg_item_t        avg_reg;
    wht_pkg::avg_item_t        avg_next;
    logic                      avg_load;
    logic [wht_pkg::SUM_W+wht_pkg::RECIP_W-1:0] product;

    // Handshake between the two stages.
    assign conv_ready = !sum_valid_reg || sum_ready;
    assign sum_load   = conv_valid && conv_ready;
    assign sum_ready  = !avg_valid_reg || avg_ready;
    assign avg_load   = sum_valid_reg && sum_ready;

    // Ring update: the oldest slot is replaced and the running sum adjusted.
    always_comb
    begin
        ring_sum_next = wht_pkg::SUM_W'(ring_sum_reg + wht_pkg::SUM_W'(conv.degrees)
                        - wht_pkg::SUM_W'(ring_reg[index_reg]));
        if (index_reg == wht_pkg::IDX_W'(wht_pkg::WINDOW_LEN - 1))
        begin
            index_next = '0;
        end
        else
        begin
            index_next = index_reg + 1'b1;
        end
        sum_item_next.onoff_press  = conv.onoff_press;
        sum_item_next.up_press     = conv.up_press;
        sum_item_next.down_press   = conv.down_press;
        sum_item_next.sample_valid = conv.sample_valid;
        sum_item_next.sum          = ring_sum_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < wht_pkg::WINDOW_LEN; i++)
            begin
                ring_reg[i] <= '0;
            end
            ring_sum_reg <= '0;
            index_reg    <= '0;
        end
        else if (sum_load && conv.sample_valid)
        begin
            ring_reg[index_reg] <= conv.degrees;
            ring_sum_reg        <= ring_sum_next;
            index_reg           <= index_next;
        end
    end

    // Division by the window length as a multiply by a rounded-up reciprocal.
    assign product = (wht_pkg::SUM_W + wht_pkg::RECIP_W)'(sum_item_reg.sum)
                   * (wht_pkg::SUM_W + wht_pkg::RECIP_W)'(wht_pkg::AVG_RECIP);

    always_comb
    begin
        avg_next.onoff_press  = sum_item_reg.onoff_press;
        avg_next.up_press     = sum_item_reg.up_press;
        avg_next.down_press   = sum_item_reg.down_press;
        avg_next.sample_valid = sum_item_reg.sample_valid;
        avg_next.average      = product[wht_pkg::AVG_SHIFT +: wht_pkg::DEG_W];
    end

    // Valid flags of both stages.
    always_comb
    begin
        if (sum_load)
        begin
            sum_valid_next = 1'b1;
        end
        else if (sum_ready)
        begin
            sum_valid_next = 1'b0;
        end
        else
        begin
            sum_valid_next = sum_valid_reg;
        end
        if (avg_load)
        begin
            avg_valid_next = 1'b1;
        end
        else if (avg_ready)
        begin
            avg_valid_next = 1'b0;
        end
        else
        begin
            avg_valid_next = avg_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_valid_reg <= 1'b0;
            avg_valid_reg <= 1'b0;
        end
        else
        begin
            sum_valid_reg <= sum_valid_next;
            avg_valid_reg <= avg_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (sum_load)
        begin
            sum_item_reg <= sum_item_next;
        end
        if (avg_load)
        begin
            avg_reg <= avg_next;
        end
    end

    assign avg_valid = avg_valid_reg;
    assign avg       = avg_reg;

    // The running sum can never exceed a full window of maximum readings.
    a_sum_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ring_sum_reg <= wht_pkg::SUM_W'(wht_pkg::WINDOW_LEN * wht_pkg::DEG_MAX))
        else $error("ring sum above full-scale window");

endmodule

/* hdl/wht_control.sv */
// Mode controller: buttons, setpoint, hysteresis, timeout, blink and the result register.
`timescale 1ns / 1ps

module wht_control (
    input  logic                clk,
    input  logic                rst_n,
    input  wht_pkg::cfg_t       cfg,
    input  logic                avg_valid,
    output logic                avg_ready,
    input  wht_pkg::avg_item_t  avg,
    output logic                result_valid,
    input  logic                result_ready,
    output wht_pkg::out_item_t  result
);

    logic [1:0]                mode_reg;
    logic [1:0]                mode_next;
    logic [6:0]                setpoint_reg;
    logic [6:0]                setpoint_next;
    logic [wht_pkg::DEG_W-1:0] current_temp_reg;
    logic [wht_pkg::DEG_W-1:0] current_temp_next;
    logic                      heater_flag_reg;
    logic                      heater_flag_next;
    logic                      cooler_flag_reg;
    logic                      cooler_flag_next;
    logic [9:0]                idle_count_reg;
    logic [9:0]                idle_count_next;
    logic [4:0]                blink_count_reg;
    logic [4:0]                blink_count_next;
    logic                      result_valid_reg;
    logic                      result_valid_next;
    wht_pkg::out_item_t        result_reg;
    wht_pkg::out_item_t        result_next;

    logic                      advance;
    logic                      any_press;
    logic                      blank;
    logic [wht_pkg::DEG_W-1:0] cur;
    logic [6:0]                sp_up;
    logic [9:0]                idle_inc;
    logic [4:0]                blink_base;
    logic [4:0]                blink_inc;

    // One item moves into the result register whenever it is free or its result is taken.
    assign avg_ready = !result_valid_reg || result_ready;
    assign advance   = avg_valid && avg_ready;
    assign any_press = avg.up_press || avg.down_press;

    // Mode logic for one tick.
    always_comb
    begin
        cur               = avg.sample_valid ? avg.average : current_temp_reg;
        mode_next         = mode_reg;
        setpoint_next     = setpoint_reg;
        current_temp_next = cur;
        heater_flag_next  = heater_flag_reg;
        cooler_flag_next  = cooler_flag_reg;
        idle_count_next   = idle_count_reg;
        blink_count_next  = blink_count_reg;
        sp_up             = setpoint_reg;
        idle_inc          = idle_count_reg + 1'b1;

        unique case (mode_reg)
            wht_pkg::MODE_RUN:
            begin
                if (avg.onoff_press)
                begin
                    mode_next = wht_pkg::MODE_OFF;
                end
                else if (any_press)
                begin
                    // Enter setting mode starting from the measured temperature.
                    mode_next        = wht_pkg::MODE_SET;
                    setpoint_next    = (cur > 9'd127) ? 7'd127 : cur[6:0];
                    idle_count_next  = '0;
                    blink_count_next = '0;
                end
                else
                begin
                    // Hysteresis band around the setpoint.
                    if (10'(cur) + 10'(cfg.hysteresis_band) <= 10'(setpoint_reg))
                    begin
                        heater_flag_next = 1'b1;
                        cooler_flag_next = 1'b0;
                    end
                    else if (10'(cur) >= 10'(setpoint_reg) + 10'(cfg.hysteresis_band))
                    begin
                        heater_flag_next = 1'b0;
                        cooler_flag_next = 1'b1;
                    end
                end
            end
            wht_pkg::MODE_SET:
            begin
                if (avg.onoff_press)
                begin
                    mode_next = wht_pkg::MODE_OFF;
                end
                else if (any_press)
                begin
                    // Up clamps at the maximum, then down clamps at the minimum.
                    idle_count_next = '0;
                    if (avg.up_press)
                    begin
                        if (8'(setpoint_reg) + 8'(cfg.setpoint_step) <= 8'(cfg.max_setpoint))
                        begin
                            sp_up = setpoint_reg + 7'(cfg.setpoint_step);
                        end
                        else
                        begin
                            sp_up = cfg.max_setpoint;
                        end
                    end
                    setpoint_next = sp_up;
                    if (avg.down_press)
                    begin
                        if (8'(sp_up) >= 8'(cfg.min_setpoint) + 8'(cfg.setpoint_step))
                        begin
                            setpoint_next = sp_up - 7'(cfg.setpoint_step);
                        end
                        else
                        begin
                            setpoint_next = cfg.min_setpoint;
                        end
                    end
                end
                else
                begin
                    // Idle timeout returns to operating with the setpoint as temperature.
                    idle_count_next = idle_inc;
                    if (idle_inc == cfg.exit_timeout)
                    begin
                        idle_count_next   = '0;
                        current_temp_next = 9'(setpoint_reg);
                        mode_next         = wht_pkg::MODE_RUN;
                    end
                end
            end
            default:
            begin
                mode_next = avg.onoff_press ? wht_pkg::MODE_RUN : wht_pkg::MODE_OFF;
            end
        endcase

        // Display blink in setting mode.
        blank      = 1'b0;
        blink_base = blink_count_next;
        blink_inc  = blink_base + 1'b1;
        if (mode_next == wht_pkg::MODE_SET)
        begin
            blink_count_next = blink_inc;
            if (blink_inc == cfg.blink_period)
            begin
                blink_count_next = '0;
                blank            = 1'b1;
            end
        end

        // Result item.
        result_next.mode = mode_next;
        if (mode_next == wht_pkg::MODE_OFF)
        begin
            result_next.heater_on     = 1'b0;
            result_next.cooler_on     = 1'b0;
            result_next.display_on    = 1'b0;
            result_next.display_value = '0;
        end
        else if (mode_next == wht_pkg::MODE_RUN)
        begin
            result_next.heater_on     = heater_flag_next;
            result_next.cooler_on     = cooler_flag_next;
            result_next.display_on    = 1'b1;
            result_next.display_value = current_temp_next;
        end
        else
        begin
            result_next.heater_on     = heater_flag_next;
            result_next.cooler_on     = cooler_flag_next;
            result_next.display_on    = !blank;
            result_next.display_value = 9'(setpoint_next);
        end
    end

    // Result valid flag.
    always_comb
    begin
        if (advance)
        begin
            result_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_next = 1'b0;
        end
        else
        begin
            result_valid_next = result_valid_reg;
        end
    end

    // Controller state, updated once per item.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg         <= wht_pkg::MODE_OFF;
            setpoint_reg     <= wht_pkg::RST_SETPOINT;
            current_temp_reg <= wht_pkg::RST_CURRENT_TEMP;
            heater_flag_reg  <= 1'b0;
            cooler_flag_reg  <= 1'b0;
            idle_count_reg   <= '0;
            blink_count_reg  <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= result_valid_next;
            if (advance)
            begin
                mode_reg         <= mode_next;
                setpoint_reg     <= setpoint_next;
                current_temp_reg <= current_temp_next;
                heater_flag_reg  <= heater_flag_next;
                cooler_flag_reg  <= cooler_flag_next;
                idle_count_reg   <= idle_count_next;
                blink_count_reg  <= blink_count_next;
            end
        end
    end

    // Result payload register.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // Heater and cooler are never requested together.
    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(heater_flag_reg && cooler_flag_reg))
        else $error("heater and cooler flags both set");

    // An off-mode result drives nothing.
    a_off_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_reg && result_reg.mode == wht_pkg::MODE_OFF) |->
        (!result_reg.heater_on && !result_reg.cooler_on && !result_reg.display_on
         && result_reg.display_value == '0))
        else $error("off-mode result drives an output");

    // An operating result shows the temperature the controller holds.
    a_run_display: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_reg && result_reg.mode == wht_pkg::MODE_RUN) |->
        (result_reg.display_on && result_reg.display_value == current_temp_reg))
        else $error("operating result does not show the held temperature");

    // A setting result shows the setpoint the controller holds.
    a_set_display: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_reg && result_reg.mode == wht_pkg::MODE_SET) |->
        (result_reg.display_value == 9'(setpoint_reg)))
        else $error("setting result does not show the held setpoint");

endmodule

/* dv/tb_top.sv */
// Testbench for the water heater thermostat: directed and random ticks checked against a predictor.
`timescale 1ns / 1ps

module tb_top;

    localparam int STALL_LIMIT = 2000;
    localparam int REPORT_MAX  = 10;

    logic                            clk;
    logic                            rst_n        = 1'b0;
    logic                            cfg_write    = 1'b0;
    logic [wht_pkg::CFG_INDEX_W-1:0] cfg_index    = '0;
    logic [wht_pkg::CFG_DATA_W-1:0]  cfg_data     = '0;
    logic                            item_valid   = 1'b0;
    logic                            item_ready;
    wht_pkg::in_item_t               item         = '0;
    logic                            result_valid;
    logic                            result_ready = 1'b0;
    wht_pkg::out_item_t              result;

    // Thermostat copy kept by the testbench: configuration and controller state.
    int         cfg_min, cfg_max, cfg_step, cfg_band, cfg_timeout, cfg_blink;
    logic [1:0] mode_now;
    int         setpoint_now, temp_now, idle_ticks, blink_ticks;
    bit         heat, cool;
    int         ring [wht_pkg::WINDOW_LEN];
    int         ring_total, ring_pos;

    // Panel outputs predicted for accepted ticks, oldest first.
    wht_pkg::out_item_t panel_queue [$];

    // Run bookkeeping.
    bit idling_on = 1'b1;
    int error_count, results_checked, ticks_sent;
    int set_entries, timeouts_seen, blank_ticks, heater_starts, cooler_starts;
    int ready_hold, quiet_cycles;

    water_heater_thermostat dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Put the thermostat copy into its reset state.
    task automatic reset_thermostat_model();
        cfg_min      = wht_pkg::RST_MIN_SETPOINT;
        cfg_max      = wht_pkg::RST_MAX_SETPOINT;
        cfg_step     = wht_pkg::RST_SETPOINT_STEP;
        cfg_band     = wht_pkg::RST_HYSTERESIS_BAND;
        cfg_timeout  = wht_pkg::RST_EXIT_TIMEOUT;
        cfg_blink    = wht_pkg::RST_BLINK_PERIOD;
        mode_now     = wht_pkg::MODE_OFF;
        setpoint_now = wht_pkg::RST_SETPOINT;
        temp_now     = wht_pkg::RST_CURRENT_TEMP;
        idle_ticks   = 0;
        blink_ticks  = 0;
        heat         = 1'b0;
        cool         = 1'b0;
        ring_total   = 0;
        ring_pos     = 0;
        foreach (ring[i])
            ring[i] = 0;
    endtask

    // Advance the thermostat copy by one tick and return the panel it shows.
    function automatic wht_pkg::out_item_t advance_thermostat(wht_pkg::in_item_t t);
        wht_pkg::out_item_t panel;
        int        deg;
        int        raised;
        int        lowered;
        bit        blank;
        panel = '0;
        blank = 1'b0;

        // The sample goes into the averaging ring first.
        if (t.sample_valid)
        begin
            deg        = (int'(t.adc_sample) * wht_pkg::ADC_SCALE) / wht_pkg::ADC_FULL;
            ring_total = ring_total - ring[ring_pos] + deg;
            ring[ring_pos] = deg;
            ring_pos   = (ring_pos + 1 >= wht_pkg::WINDOW_LEN) ? 0 : ring_pos + 1;
            temp_now   = ring_total / wht_pkg::WINDOW_LEN;
        end

        // Mode logic; the on/off button wins over up and down.
        if (mode_now == wht_pkg::MODE_RUN || mode_now == wht_pkg::MODE_SET)
        begin
            if (t.onoff_press)
                mode_now = wht_pkg::MODE_OFF;
            else if (mode_now == wht_pkg::MODE_RUN)
            begin
                if (t.up_press || t.down_press)
                begin
                    mode_now     = wht_pkg::MODE_SET;
                    setpoint_now = (temp_now > 127) ? 127 : temp_now;
                    idle_ticks   = 0;
                    blink_ticks  = 0;
                    set_entries++;
                end
                else if (temp_now <= setpoint_now - cfg_band)
                begin
                    if (!heat)
                        heater_starts++;
                    heat = 1'b1;
                    cool = 1'b0;
                end
                else if (temp_now >= setpoint_now + cfg_band)
                begin
                    if (!cool)
                        cooler_starts++;
                    heat = 1'b0;
                    cool = 1'b1;
                end
            end
            else if (t.up_press || t.down_press)
            begin
                idle_ticks = 0;
                if (t.up_press)
                begin
                    raised       = setpoint_now + cfg_step;
                    setpoint_now = (raised <= cfg_max) ? raised : cfg_max;
                end
                if (t.down_press)
                begin
                    lowered      = setpoint_now - cfg_step;
                    setpoint_now = (lowered >= cfg_min) ? lowered : cfg_min;
                end
            end
            else
            begin
                idle_ticks = (idle_ticks + 1) % 1024;
                if (idle_ticks == cfg_timeout)
                begin
                    idle_ticks = 0;
                    temp_now   = setpoint_now;
                    mode_now   = wht_pkg::MODE_RUN;
                    timeouts_seen++;
                end
            end
        end
        else if (t.onoff_press)
            mode_now = wht_pkg::MODE_RUN;

        // The display blanks once per blink period while setting.
        if (mode_now == wht_pkg::MODE_SET)
        begin
            blink_ticks = (blink_ticks + 1) % 32;
            if (blink_ticks == cfg_blink)
            begin
                blink_ticks = 0;
                blank       = 1'b1;
                blank_ticks++;
            end
        end

        panel.mode = mode_now;
        if (mode_now != wht_pkg::MODE_OFF)
        begin
            panel.heater_on     = heat;
            panel.cooler_on     = cool;
            panel.display_on    = !blank;
            panel.display_value = (mode_now == wht_pkg::MODE_RUN)
                                  ? wht_pkg::DEG_W'(temp_now)
                                  : wht_pkg::DEG_W'(setpoint_now);
        end
        return panel;
    endfunction

    // Write one register, both in the block and in the thermostat copy.
    task automatic write_reg(logic [wht_pkg::CFG_INDEX_W-1:0] idx, int value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= wht_pkg::CFG_DATA_W'(value);
        @(posedge clk);
        cfg_write <= 1'b0;
        @(posedge clk);
        case (idx)
            wht_pkg::CFG_MIN_SETPOINT:    cfg_min     = value & 127;
            wht_pkg::CFG_MAX_SETPOINT:    cfg_max     = value & 127;
            wht_pkg::CFG_SETPOINT_STEP:   cfg_step    = value & 15;
            wht_pkg::CFG_HYSTERESIS_BAND: cfg_band    = value & 15;
            wht_pkg::CFG_EXIT_TIMEOUT:    cfg_timeout = value & 1023;
            wht_pkg::CFG_BLINK_PERIOD:    cfg_blink   = value & 31;
            default: ;
        endcase
    endtask

    task automatic apply_config(int min_sp, int max_sp, int step, int band, int timeout,
                                int blink);
        write_reg(wht_pkg::CFG_MIN_SETPOINT, min_sp);
        write_reg(wht_pkg::CFG_MAX_SETPOINT, max_sp);
        write_reg(wht_pkg::CFG_SETPOINT_STEP, step);
        write_reg(wht_pkg::CFG_HYSTERESIS_BAND, band);
        write_reg(wht_pkg::CFG_EXIT_TIMEOUT, timeout);
        write_reg(wht_pkg::CFG_BLINK_PERIOD, blink);
    endtask

    // Offer one tick, wait for it to be taken, and record its predicted panel.
    // Valid stays high afterward so that back-to-back ticks need no gap.
    task automatic send_tick(wht_pkg::in_item_t t);
        if (idling_on && $urandom_range(0, 5) == 0)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= t;
        do
            @(posedge clk);
        while (!item_ready);
        panel_queue.push_back(advance_thermostat(t));
        ticks_sent++;
    endtask

    // Stop offering ticks and let every outstanding result come back.
    task automatic drain();
        item_valid <= 1'b0;
        while (panel_queue.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    function automatic wht_pkg::in_item_t tick_of(bit onoff, bit up, bit down, bit sv,
                                                  int adc);
        wht_pkg::in_item_t t;
        t.onoff_press  = onoff;
        t.up_press     = up;
        t.down_press   = down;
        t.sample_valid = sv;
        t.adc_sample   = wht_pkg::ADC_W'(adc);
        return t;
    endfunction

    // Random tick: samples mostly near a target temperature, sometimes anywhere.
    function automatic wht_pkg::in_item_t random_tick(int press_pct, int target,
                                                      bit presses);
        int deg;
        int adc;
        adc = $urandom_range(0, 1023);
        if ($urandom_range(0, 3) != 0)
        begin
            deg = target + $urandom_range(0, 16) - 8;
            deg = (deg < 0) ? 0 : (deg > wht_pkg::DEG_MAX) ? wht_pkg::DEG_MAX : deg;
            adc = deg * wht_pkg::ADC_FULL / wht_pkg::ADC_SCALE + $urandom_range(0, 2);
            adc = (adc > 1023) ? 1023 : adc;
        end
        return tick_of(presses && $urandom_range(0, 99) < 2,
                       presses && $urandom_range(0, 99) < press_pct,
                       presses && $urandom_range(0, 99) < press_pct,
                       $urandom_range(0, 9) < 6, adc);
    endfunction

    // Buttons in every mode, sample extremes and the on/off priority.
    task automatic test_button_sequences();
        send_tick(tick_of(0, 0, 0, 0, 0));
        send_tick(tick_of(0, 1, 1, 0, 1023));
        send_tick(tick_of(0, 0, 0, 1, 1023));
        send_tick(tick_of(1, 0, 0, 0, 0));
        send_tick(tick_of(0, 0, 0, 1, 0));
        send_tick(tick_of(0, 0, 0, 1, 1));
        send_tick(tick_of(0, 0, 0, 1, 3));
        send_tick(tick_of(0, 0, 0, 1, 1022));
        send_tick(tick_of(0, 0, 0, 1, 'h2AA));
        send_tick(tick_of(0, 0, 0, 1, 'h155));
        repeat (4) send_tick(tick_of(0, 0, 0, 1, 1023));
        send_tick(tick_of(0, 1, 0, 0, 0));
        send_tick(tick_of(0, 0, 1, 0, 0));
        send_tick(tick_of(0, 1, 1, 0, 0));
        send_tick(tick_of(0, 1, 0, 0, 0));
        send_tick(tick_of(0, 0, 1, 1, 512));
        send_tick(tick_of(1, 1, 0, 0, 0));
        send_tick(tick_of(1, 0, 0, 0, 0));
        send_tick(tick_of(0, 0, 0, 0, 0));
        send_tick(tick_of(1, 0, 1, 0, 0));
        drain();
    endtask

    // Widest limits, largest step, zero band and the shortest timeout and blink.
    task automatic test_register_extremes();
        apply_config(0, 127, 15, 0, 1, 1);
        send_tick(tick_of(1, 0, 0, 1, 512));
        send_tick(tick_of(0, 0, 0, 1, 1023));
        send_tick(tick_of(0, 0, 0, 1, 0));
        send_tick(tick_of(0, 1, 0, 0, 0));
        repeat (9) send_tick(tick_of(0, 0, 1, 0, $urandom_range(0, 1023)));
        repeat (9) send_tick(tick_of(0, 1, 0, 0, $urandom_range(0, 1023)));
        send_tick(tick_of(0, 0, 0, 0, 0));
        send_tick(tick_of(0, 0, 0, 0, 0));
        send_tick(tick_of(0, 0, 0, 1, 0));
        drain();
    endtask

    // Limits set the wrong way round, then a long idle timeout and the longest blink period.
    task automatic test_long_setting_timeout();
        apply_config(127, 0, 1, 15, 600, 31);
        send_tick(tick_of(0, 1, 0, 1, 300));
        send_tick(tick_of(0, 1, 0, 0, 0));
        send_tick(tick_of(0, 0, 1, 0, 0));
        send_tick(tick_of(0, 1, 1, 0, 0));
        repeat (610) send_tick(random_tick(0, 60, 1'b0));
        send_tick(tick_of(1, 0, 0, 0, 0));
        drain();
    endtask

    // Random phases, each with its own register setting; the last one runs without gaps.
    task automatic test_random_ticks();
        int phases;
        int min_sp;
        int max_sp;
        int swap;
        int press_pct;
        int target;
        phases = 6;
        for (int p = 0; p < phases; p++)
        begin
            min_sp = $urandom_range(0, 90);
            max_sp = $urandom_range(min_sp, 127);
            if ($urandom_range(0, 7) == 0)
            begin
                swap   = min_sp;
                min_sp = max_sp;
                max_sp = swap;
            end
            apply_config(min_sp, max_sp, $urandom_range(1, 15), $urandom_range(0, 15),
                         ($urandom_range(0, 4) == 0) ? $urandom_range(1, 1023)
                                                     : $urandom_range(1, 40),
                         $urandom_range(1, 31));
            idling_on = (p != phases - 1);
            press_pct = $urandom_range(2, 15);
            target    = $urandom_range(20, 110);
            if (mode_now == wht_pkg::MODE_OFF)
                send_tick(tick_of(1, 0, 0, 0, 0));
            repeat (90)
            begin
                if ($urandom_range(0, 7) == 0)
                    target = target + $urandom_range(0, 6) - 3;
                target = (target < 0) ? 0 : (target > 150) ? 150 : target;
                send_tick(random_tick(press_pct, target, 1'b1));
            end
            drain();
        end
    endtask

    // Result side: random stall bursts while idling is on.
    always @(posedge clk)
    begin
        if (ready_hold > 0)
        begin
            ready_hold--;
            result_ready <= 1'b0;
        end
        else if (idling_on && $urandom_range(0, 5) == 0)
        begin
            ready_hold = $urandom_range(0, 4);
            result_ready <= 1'b0;
        end
        else
            result_ready <= 1'b1;
    end

    task automatic report_bad_result(string why, wht_pkg::out_item_t want,
                                     wht_pkg::out_item_t got);
        error_count++;
        if (error_count <= REPORT_MAX)
            $display("mismatch (%s): expected mode %0d heat %0b cool %0b lit %0b value %0d,",
                     why, want.mode, want.heater_on, want.cooler_on, want.display_on,
                     want.display_value,
                     " got mode %0d heat %0b cool %0b lit %0b value %0d",
                     got.mode, got.heater_on, got.cooler_on, got.display_on,
                     got.display_value);
    endtask

    // Compare each accepted result with the oldest predicted panel.
    always @(posedge clk)
    begin : check_panel
        wht_pkg::out_item_t want;
        if (rst_n && result_valid && result_ready)
        begin
            results_checked++;
            if (panel_queue.size() == 0)
                report_bad_result("no tick waiting", '0, result);
            else
            begin
                want = panel_queue.pop_front();
                if (result.mode !== want.mode || result.heater_on !== want.heater_on ||
                    result.cooler_on !== want.cooler_on ||
                    result.display_on !== want.display_on ||
                    result.display_value !== want.display_value)
                    report_bad_result("wrong field", want, result);
            end
        end
    end

    // Watchdog: end the run when nothing moves on either side for too long.
    always @(posedge clk)
    begin
        if ((item_valid && item_ready) || (result_valid && result_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("watchdog: nothing accepted for %0d cycles, %0d results outstanding",
                     quiet_cycles, panel_queue.size());
            $display("tb: failure");
            $finish;
        end
    end

    // Test sequence.
    initial
    begin
        reset_thermostat_model();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_button_sequences();
        test_register_extremes();
        test_long_setting_timeout();
        test_random_ticks();
        repeat (10) @(posedge clk);
        $display("Sent %0d ticks and checked %0d results over %0d setting entries,",
                 ticks_sent, results_checked, set_entries,
                 " %0d idle timeouts and %0d blanked display ticks.",
                 timeouts_seen, blank_ticks);
        $display("Heater switched on %0d times, cooler %0d times; %0d mismatches.",
                 heater_starts, cooler_starts, error_count);
        if (error_count == 0 && panel_queue.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
